// File: src/dwce_pkg.sv
// Shared types and constants for the display window cursor engine.
`default_nettype none

package dwce_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_GOTO = 2'd2;
  localparam logic [1:0] KIND_DOT  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIN_LEFT   = 2'd0;
  localparam logic [1:0] CFG_WIN_TOP    = 2'd1;
  localparam logic [1:0] CFG_WIN_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_WIN_HEIGHT = 2'd3;

  // Window reset values
  localparam logic [6:0] WIN_LEFT_RST   = 7'd0;
  localparam logic [2:0] WIN_TOP_RST    = 3'd0;
  localparam logic [6:0] WIN_WIDTH_RST  = 7'd84;
  localparam logic [2:0] WIN_HEIGHT_RST = 3'd6;

  // Display command prefixes for the address pair
  localparam logic [7:0] CMD_COL = 8'h80;
  localparam logic [7:0] CMD_ROW = 8'h40;

  // Output byte source select
  localparam logic [1:0] EMIT_PASS = 2'd0;
  localparam logic [1:0] EMIT_DATA = 2'd1;
  localparam logic [1:0] EMIT_COL  = 2'd2;
  localparam logic [1:0] EMIT_ROW  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
  } in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       set_cursor;
    logic       cur_src_dot;
    logic       div_start;
    logic       div_y;
    logic       ram_read;
    logic       data_write;
    logic       data_dot;
    logic       emit;
    logic [1:0] emit_sel;
    logic       last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic wrap;
  } status_t;

endpackage

`default_nettype wire

// File: src/dwce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dwce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/dwce_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module dwce_rem #(
  parameter int DW = 8,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [VW-1:0] rem
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] d_r, d_nxt;
  logic [VW-1:0] r_r, r_nxt;
  logic [VW:0]   trial;

  // One shift-and-subtract step
  always_comb begin
    trial    = {r_r, q_r[DW-1]};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = dividend;
      d_nxt   = divisor;
      r_nxt   = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        trial = trial - {1'b0, d_r};
      end
      r_nxt   = trial[VW-1:0];
      q_nxt   = {q_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

// File: src/dwce_ctrl.sv
// Controller state machine: sequences clear pass and each input kind.
`default_nettype none

module dwce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        kind,
  input  wire dwce_pkg::status_t st,
  output dwce_pkg::cmd_t         cmd,
  output logic                   busy
);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_PASS    = 4'd2;
  localparam logic [3:0] ST_GOTO    = 4'd3;
  localparam logic [3:0] ST_DIVX_GO = 4'd4;
  localparam logic [3:0] ST_DIVX_WT = 4'd5;
  localparam logic [3:0] ST_DIVY_GO = 4'd6;
  localparam logic [3:0] ST_DIVY_WT = 4'd7;
  localparam logic [3:0] ST_DOTSET  = 4'd8;
  localparam logic [3:0] ST_ADDRC   = 4'd9;
  localparam logic [3:0] ST_ADDRR   = 4'd10;
  localparam logic [3:0] ST_READ    = 4'd11;
  localparam logic [3:0] ST_DATA    = 4'd12;
  localparam logic [3:0] ST_WRAPC   = 4'd13;
  localparam logic [3:0] ST_WRAPR   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       dot_r, dot_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    dot_nxt   = dot_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          dot_nxt  = (kind == dwce_pkg::KIND_DOT);
          case (kind)
            dwce_pkg::KIND_DATA: state_nxt = ST_DATA;
            dwce_pkg::KIND_PASS: state_nxt = ST_PASS;
            dwce_pkg::KIND_GOTO: state_nxt = ST_GOTO;
            dwce_pkg::KIND_DOT:  state_nxt = ST_DIVX_GO;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PASS: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = dwce_pkg::EMIT_PASS;
        cmd.last     = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_GOTO: begin
        cmd.set_cursor = 1'b1;
        state_nxt      = ST_ADDRC;
      end
      ST_DIVX_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVX_WT;
      end
      ST_DIVX_WT: begin
        if (st.div_done) begin
          state_nxt = ST_DIVY_GO;
        end
      end
      ST_DIVY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_y     = 1'b1;
        state_nxt     = ST_DIVY_WT;
      end
      ST_DIVY_WT: begin
        cmd.div_y = 1'b1;
        if (st.div_done) begin
          state_nxt = ST_DOTSET;
        end
      end
      ST_DOTSET: begin
        cmd.set_cursor  = 1'b1;
        cmd.cur_src_dot = 1'b1;
        state_nxt       = ST_ADDRC;
      end
      ST_ADDRC: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = dwce_pkg::EMIT_COL;
        state_nxt    = ST_ADDRR;
      end
      ST_ADDRR: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = dwce_pkg::EMIT_ROW;
        cmd.last     = !dot_r;
        state_nxt    = dot_r ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd.ram_read = 1'b1;
        state_nxt    = ST_DATA;
      end
      ST_DATA: begin
        cmd.data_write = 1'b1;
        cmd.data_dot   = dot_r;
        cmd.emit       = 1'b1;
        cmd.emit_sel   = dwce_pkg::EMIT_DATA;
        cmd.last       = !st.wrap;
        state_nxt      = st.wrap ? ST_WRAPC : ST_IDLE;
      end
      ST_WRAPC: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = dwce_pkg::EMIT_COL;
        state_nxt    = ST_WRAPR;
      end
      ST_WRAPR: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = dwce_pkg::EMIT_ROW;
        cmd.last     = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      dot_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dot_r   <= dot_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// File: src/dwce_dp.sv
// Datapath: window registers, cursor, shadow RAM, remainder unit, output register.
`default_nettype none

module dwce_dp #(
  parameter int COLUMNS   = 84,
  parameter int BYTE_ROWS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dwce_pkg::cmd_t    cmd,
  output dwce_pkg::status_t      st,
  input  wire dwce_pkg::in_t     in_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [6:0]        cfg_data,
  output logic                   out_valid,
  output dwce_pkg::out_t         out_data
);

  localparam int DEPTH = COLUMNS * BYTE_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_W = 7 + $clog2(BYTE_ROWS + 1) + 1;

  // Window registers
  logic [6:0] win_left_r;
  logic [2:0] win_top_r;
  logic [6:0] win_width_r;
  logic [2:0] win_height_r;

  // Cursor and latched input
  logic [6:0] cursor_col_r, cursor_col_nxt;
  logic [2:0] cursor_row_r, cursor_row_nxt;
  dwce_pkg::in_t item_r;
  logic [6:0] dot_col_r;
  logic [2:0] dot_row_r;

  // Clearing pass
  logic [AW-1:0] clr_cnt_r;

  // Output register
  logic           out_valid_r;
  dwce_pkg::out_t out_r;

  logic [6:0]       w_eff, wm1;
  logic [2:0]       h_eff, hm1;
  logic [7:0]       src_x, src_y;
  logic [6:0]       sat_col;
  logic [2:0]       sat_row;
  logic [IDX_W-1:0] idx_full;
  logic [AW-1:0]    idx;
  logic [7:0]       rd_data;
  logic [7:0]       wr_byte;
  logic [7:0]       col_byte, row_byte;
  logic [6:0]       col_sum;
  logic [3:0]       row_sum;
  logic [7:0]       col_inc;
  logic [3:0]       row_inc;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             rem_done;
  logic [6:0]       rem_val;
  logic [7:0]       div_dividend;
  logic [6:0]       div_divisor;

  // Effective window size: zero acts as one, oversize clips to the panel
  always_comb begin
    if (win_width_r == 7'd0) begin
      w_eff = 7'd1;
    end else if ({1'b0, win_width_r} > 8'(COLUMNS)) begin
      w_eff = 7'(COLUMNS);
    end else begin
      w_eff = win_width_r;
    end
    if (win_height_r == 3'd0) begin
      h_eff = 3'd1;
    end else if ({1'b0, win_height_r} > 4'(BYTE_ROWS)) begin
      h_eff = 3'(BYTE_ROWS);
    end else begin
      h_eff = win_height_r;
    end
  end

  assign wm1 = w_eff - 7'd1;
  assign hm1 = h_eff - 3'd1;

  // Cursor load source, saturated to the window
  assign src_x   = cmd.cur_src_dot ? {1'b0, dot_col_r} : item_r.x_pos;
  assign src_y   = cmd.cur_src_dot ? {5'b0, dot_row_r} : item_r.y_pos;
  assign sat_col = (src_x > {1'b0, wm1}) ? wm1 : src_x[6:0];
  assign sat_row = (src_y > {5'b0, hm1}) ? hm1 : src_y[2:0];

  // Shadow RAM index of the cursor
  assign idx_full = IDX_W'(cursor_col_r) * IDX_W'(BYTE_ROWS) + IDX_W'(cursor_row_r);
  assign idx      = (idx_full >= IDX_W'(DEPTH)) ? '0 : idx_full[AW-1:0];

  // Cursor advance and wrap detect
  assign col_inc = {1'b0, cursor_col_r} + 8'd1;
  assign row_inc = {1'b0, cursor_row_r} + 4'd1;
  assign st.wrap = (col_inc >= {1'b0, w_eff});

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    if (cfg_we) begin
      cursor_col_nxt = '0;
      cursor_row_nxt = '0;
    end else if (cmd.set_cursor) begin
      cursor_col_nxt = sat_col;
      cursor_row_nxt = sat_row;
    end else if (cmd.data_write) begin
      if (st.wrap) begin
        cursor_col_nxt = '0;
        cursor_row_nxt = (row_inc > {1'b0, hm1}) ? 3'd0 : row_inc[2:0];
      end else begin
        cursor_col_nxt = col_inc[6:0];
      end
    end
  end

  // Window registers and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= dwce_pkg::WIN_LEFT_RST;
      win_top_r    <= dwce_pkg::WIN_TOP_RST;
      win_width_r  <= dwce_pkg::WIN_WIDTH_RST;
      win_height_r <= dwce_pkg::WIN_HEIGHT_RST;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dwce_pkg::CFG_WIN_LEFT:   win_left_r   <= cfg_data;
          dwce_pkg::CFG_WIN_TOP:    win_top_r    <= cfg_data[2:0];
          dwce_pkg::CFG_WIN_WIDTH:  win_width_r  <= cfg_data;
          dwce_pkg::CFG_WIN_HEIGHT: win_height_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  // Input latch and dot coordinates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (rem_done && !cmd.div_y) begin
      dot_col_r <= rem_val;
    end
    if (rem_done && cmd.div_y) begin
      dot_row_r <= rem_val[2:0];
    end
  end

  // Remainder operands: column mod width, then byte row mod height
  assign div_dividend = cmd.div_y ? {3'b0, item_r.y_pos[7:3]} : item_r.x_pos;
  assign div_divisor  = cmd.div_y ? {4'b0, h_eff} : w_eff;

  dwce_rem #(
    .DW (8),
    .VW (7)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign st.div_done = rem_done;

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear && !st.clear_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign st.clear_done = (clr_cnt_r == AW'(DEPTH - 1));

  // Byte to store and send: plain data or shadow byte with the dot set
  assign wr_byte = cmd.data_dot ? (rd_data | (8'd1 << item_r.y_pos[2:0]))
                                : item_r.data_byte;

  assign ram_we    = cmd.clear | cmd.data_write;
  assign ram_waddr = cmd.clear ? clr_cnt_r : idx;
  assign ram_wdata = cmd.clear ? 8'd0 : wr_byte;

  dwce_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ram_read),
    .raddr (idx),
    .rdata (rd_data)
  );

  // Address pair bytes from the current cursor
  assign col_sum  = win_left_r + cursor_col_r;
  assign row_sum  = {1'b0, win_top_r} + {1'b0, cursor_row_r};
  assign col_byte = dwce_pkg::CMD_COL | {1'b0, col_sum};
  assign row_byte = dwce_pkg::CMD_ROW | {4'b0, row_sum};

  // Output register, one strobe per result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.last <= cmd.last;
      case (cmd.emit_sel)
        dwce_pkg::EMIT_PASS: begin
          out_r.is_data  <= 1'b0;
          out_r.lcd_byte <= item_r.data_byte;
        end
        dwce_pkg::EMIT_DATA: begin
          out_r.is_data  <= 1'b1;
          out_r.lcd_byte <= wr_byte;
        end
        dwce_pkg::EMIT_COL: begin
          out_r.is_data  <= 1'b0;
          out_r.lcd_byte <= col_byte;
        end
        dwce_pkg::EMIT_ROW: begin
          out_r.is_data  <= 1'b0;
          out_r.lcd_byte <= row_byte;
        end
        default: begin
          out_r.is_data  <= 1'b0;
          out_r.lcd_byte <= 8'd0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/display_window_cursor_engine.sv
// Top level of the display window cursor engine: controller plus datapath.
//
//  channel  ports                            transfer when
//  -------  -------------------------------  ------------------------------
//  input    start, busy, in_data             start high and busy low
//  result   out_valid, out_data              out_valid high (one cycle)
//  config   cfg_valid, cfg_ready, cfg_index,  cfg_valid and cfg_ready high
//           cfg_data
//
// A command passthrough sends its byte; a data write sends the byte and, on a
// column wrap, the address pair; a goto sends the address pair. A dot runs
// two 8-step shift-subtract remainders on the shared remainder unit, then
// sends the address pair and does a shadow RAM read and write.
// After reset a clearing pass zeroes all COLUMNS*BYTE_ROWS shadow RAM bytes
// (504 at default size), with busy high; configuration writes are taken.
// Result bytes come one per cycle while the controller is emitting, and cannot be held off by the receiver.
`default_nettype none

module display_window_cursor_engine #(
  parameter int COLUMNS   = 84,
  parameter int BYTE_ROWS = 6
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire dwce_pkg::in_t  in_data,
  output logic                out_valid,
  output dwce_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [6:0]     cfg_data
);

  dwce_pkg::cmd_t    cmd;
  dwce_pkg::status_t st;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  dwce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  dwce_dp #(
    .COLUMNS   (COLUMNS),
    .BYTE_ROWS (BYTE_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench for the display window cursor engine: directed plan, random phases, byte predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int COLUMNS      = 84;
  localparam int BYTE_ROWS    = 6;
  localparam int RANDOM_ITEMS = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 40;

  // One line of the directed plan: a window register write or an input item,
  // optionally with up to two expected bytes typed in by hand
  typedef struct packed {
    logic                  is_cfg;
    logic [1:0]            cfg_idx;
    logic [6:0]            cfg_val;
    dwce_pkg::in_t         item;
    logic [1:0]            n_typed;
    dwce_pkg::out_t [1:0]  typed;
  } plan_row_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  dwce_pkg::in_t  in_data;
  logic           out_valid;
  dwce_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [6:0]     cfg_data;

  display_window_cursor_engine #(
    .COLUMNS  (COLUMNS),
    .BYTE_ROWS(BYTE_ROWS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow RAM, cursor and window registers
  logic [7:0] shadow_q [COLUMNS*BYTE_ROWS];
  logic [6:0] cur_col_q;
  logic [2:0] cur_row_q;
  logic [6:0] win_left_q;
  logic [2:0] win_top_q;
  logic [6:0] win_width_q;
  logic [2:0] win_height_q;

  dwce_pkg::out_t step_bytes[$];
  dwce_pkg::out_t expected_lcd_bytes[$];
  int             mismatches   = 0;
  int             stall_cycles = 0;

  // Effective window size: zero acts as one, oversize clamps to the panel
  function automatic int span_cols();
    int w;
    w = win_width_q;
    if (w == 0) w = 1;
    if (w > COLUMNS) w = COLUMNS;
    return w;
  endfunction

  function automatic int span_rows();
    int h;
    h = win_height_q;
    if (h == 0) h = 1;
    if (h > BYTE_ROWS) h = BYTE_ROWS;
    return h;
  endfunction

  function automatic dwce_pkg::out_t lcd(logic d, logic [7:0] b, logic l);
    dwce_pkg::out_t r;
    r.is_data  = d;
    r.lcd_byte = b;
    r.last     = l;
    return r;
  endfunction

  function automatic void emit_lcd(logic d, logic [7:0] b);
    step_bytes.push_back(lcd(d, b, 1'b0));
  endfunction

  // Column/row address pair for the current cursor, both commands
  function automatic void emit_address();
    logic [6:0] col;
    logic [5:0] row;
    col = win_left_q + cur_col_q;
    row = 6'(win_top_q) + 6'(cur_row_q);
    emit_lcd(1'b0, dwce_pkg::CMD_COL | {1'b0, col});
    emit_lcd(1'b0, dwce_pkg::CMD_ROW | {2'b00, row});
  endfunction

  // Goto saturates each coordinate to the window
  function automatic void move_cursor(int x, int y);
    int w;
    int h;
    w = span_cols();
    h = span_rows();
    cur_col_q = 7'((x > w - 1) ? w - 1 : x);
    cur_row_q = 3'((y > h - 1) ? h - 1 : y);
    emit_address();
  endfunction

  function automatic int shadow_index();
    int idx;
    idx = cur_col_q * BYTE_ROWS + cur_row_q;
    if (idx >= COLUMNS * BYTE_ROWS) idx = 0;
    return idx;
  endfunction

  // Data write: send, store, advance; a column wrap re-sends the address
  function automatic void store_byte(logic [7:0] b);
    int w;
    int h;
    int col;
    w = span_cols();
    h = span_rows();
    emit_lcd(1'b1, b);
    shadow_q[shadow_index()] = b;
    col = cur_col_q + 1;
    if (col > w - 1) begin
      cur_col_q = '0;
      if (cur_row_q + 1 > h - 1) cur_row_q = '0;
      else cur_row_q = cur_row_q + 3'd1;
      emit_address();
    end else begin
      cur_col_q = 7'(col);
    end
  endfunction

  // Bytes caused by one accepted input item, last one flagged
  function automatic void predict_lcd_bytes(dwce_pkg::in_t it);
    int             xx;
    int             yy;
    logic [7:0]     v;
    dwce_pkg::out_t tail;
    step_bytes.delete();
    case (it.kind)
      dwce_pkg::KIND_DATA: store_byte(it.data_byte);
      dwce_pkg::KIND_PASS: emit_lcd(1'b0, it.data_byte);
      dwce_pkg::KIND_GOTO: move_cursor(it.x_pos, it.y_pos);
      default: begin
        // plot dot
        xx = it.x_pos % span_cols();
        yy = it.y_pos % (span_rows() * 8);
        move_cursor(xx, yy / 8);
        v = shadow_q[shadow_index()] | (8'd1 << (yy % 8));
        store_byte(v);
      end
    endcase
    tail = step_bytes.pop_back();
    tail.last = 1'b1;
    step_bytes.push_back(tail);
  endfunction

  // Any register write homes the cursor; the shadow RAM is kept
  function automatic void apply_window_reg(logic [1:0] idx, logic [6:0] val);
    case (idx)
      dwce_pkg::CFG_WIN_LEFT:   win_left_q   = val;
      dwce_pkg::CFG_WIN_TOP:    win_top_q    = val[2:0];
      dwce_pkg::CFG_WIN_WIDTH:  win_width_q  = val;
      dwce_pkg::CFG_WIN_HEIGHT: win_height_q = val[2:0];
      default: ;
    endcase
    cur_col_q = '0;
    cur_row_q = '0;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] k, logic [7:0] d, logic [7:0] x,
                                         logic [7:0] y, logic [1:0] n = 2'd0,
                                         dwce_pkg::out_t e0 = '0,
                                         dwce_pkg::out_t e1 = '0);
    plan_row_t r;
    r = '0;
    r.item.kind      = k;
    r.item.data_byte = d;
    r.item.x_pos     = x;
    r.item.y_pos     = y;
    r.n_typed        = n;
    r.typed[0]       = e0;
    r.typed[1]       = e1;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [1:0] idx, logic [6:0] v);
    plan_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = v;
    return r;
  endfunction

  // Mostly back-to-back, sometimes short gaps, now and then a long one
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Register values biased toward the extremes and small windows
  function automatic logic [6:0] pick_window_value(logic [1:0] idx);
    int         r;
    logic [6:0] v;
    r = $urandom_range(0, 7);
    v = 7'($urandom);
    case (idx)
      dwce_pkg::CFG_WIN_LEFT:
        if (r == 0) v = 7'd0;
        else if (r == 1) v = 7'd127;
        else if (r < 5) v = 7'($urandom_range(0, 83));
      dwce_pkg::CFG_WIN_TOP:
        if (r == 0) v = 7'd0;
        else if (r == 1) v = 7'd7;
        else if (r < 5) v = 7'($urandom_range(0, 5));
      dwce_pkg::CFG_WIN_WIDTH:
        if (r == 0) v = 7'd0;
        else if (r == 1) v = 7'd1;
        else if (r == 2) v = 7'd84;
        else if (r == 3) v = 7'd127;
        else if (r < 6) v = 7'($urandom_range(1, 6));
        else v = 7'($urandom_range(1, 84));
      dwce_pkg::CFG_WIN_HEIGHT:
        if (r == 0) v = 7'd0;
        else if (r == 1) v = 7'd1;
        else if (r == 2) v = 7'd6;
        else if (r == 3) v = 7'd7;
        else if (r < 6) v = 7'($urandom_range(1, 3));
      default: ;
    endcase
    return v;
  endfunction

  // Random item; half the gotos and dots stay near the window
  function automatic dwce_pkg::in_t random_item();
    dwce_pkg::in_t it;
    int            r;
    r = $urandom_range(0, 99);
    it.kind      = (r < 40) ? dwce_pkg::KIND_DATA :
                   (r < 50) ? dwce_pkg::KIND_PASS :
                   (r < 65) ? dwce_pkg::KIND_GOTO : dwce_pkg::KIND_DOT;
    it.data_byte = 8'($urandom);
    it.x_pos     = 8'($urandom);
    it.y_pos     = 8'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      if (it.kind == dwce_pkg::KIND_GOTO) begin
        it.x_pos = 8'($urandom_range(0, span_cols()));
        it.y_pos = 8'($urandom_range(0, span_rows()));
      end else if (it.kind == dwce_pkg::KIND_DOT) begin
        it.x_pos = 8'($urandom_range(0, span_cols() - 1));
        it.y_pos = 8'($urandom_range(0, span_rows() * 8 - 1));
      end
    end
    return it;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Entered and left at a falling edge; start stays high for a following item
  task automatic send_item(dwce_pkg::in_t it, logic [1:0] n_typed,
                           dwce_pkg::out_t [1:0] typed);
    in_data = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    predict_lcd_bytes(it);
    if (n_typed == 2'd0) begin
      for (int k = 0; k < step_bytes.size(); k++) expected_lcd_bytes.push_back(step_bytes[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) expected_lcd_bytes.push_back(typed[k]);
    end
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      start = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Hold off until every expected byte has come and the block is idle
  task automatic drain_lcd_bytes();
    start = 1'b0;
    do @(posedge clk); while (expected_lcd_bytes.size() != 0 || busy);
    @(negedge clk);
  endtask

  // Caller lowers cfg_valid once the burst of writes is over
  task automatic write_window_reg(logic [1:0] idx, logic [6:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_window_reg(idx, val);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    dwce_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_lcd_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected lcd transfer: data=%0d byte=%02h last=%0d",
                                out_data.is_data, out_data.lcd_byte, out_data.last));
      end else begin
        want = expected_lcd_bytes.pop_front();
        if (out_data.is_data !== want.is_data || out_data.lcd_byte !== want.lcd_byte ||
            out_data.last !== want.last) begin
          note_mismatch($sformatf(
            "lcd mismatch: expected data=%0d byte=%02h last=%0d, got data=%0d byte=%02h last=%0d",
            want.is_data, want.lcd_byte, want.last,
            out_data.is_data, out_data.lcd_byte, out_data.last));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t  plan[$];
    int         sent;
    int         nwrites;
    int         nitems;
    bit         quiet;
    logic [1:0] idx;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    foreach (shadow_q[i]) shadow_q[i] = '0;
    cur_col_q    = '0;
    cur_row_q    = '0;
    win_left_q   = dwce_pkg::WIN_LEFT_RST;
    win_top_q    = dwce_pkg::WIN_TOP_RST;
    win_width_q  = dwce_pkg::WIN_WIDTH_RST;
    win_height_q = dwce_pkg::WIN_HEIGHT_RST;

    // Default window: byte extremes, goto past the corner, wrap, dots
    plan.push_back(item_row(dwce_pkg::KIND_PASS, 8'h00, 8'h00, 8'h00, 2'd1,
                            lcd(1'b0, 8'h00, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_PASS, 8'hFF, 8'hFF, 8'hFF, 2'd1,
                            lcd(1'b0, 8'hFF, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'hA5, 8'h00, 8'h00, 2'd1,
                            lcd(1'b1, 8'hA5, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_GOTO, 8'h00, 8'hFF, 8'hFF, 2'd2,
                            lcd(1'b0, 8'hD3, 1'b0), lcd(1'b0, 8'h45, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'hFF, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'h00, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'hFF, 8'hFF, 8'hFF));
    plan.push_back(item_row(dwce_pkg::KIND_GOTO, 8'h00, 8'h00, 8'h00, 2'd2,
                            lcd(1'b0, 8'h80, 1'b0), lcd(1'b0, 8'h40, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h00, 8'h00, 8'h00, 2'd1,
                            lcd(1'b1, 8'h00, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'h5A, 8'h80, 8'h7F));
    // Zero-size window at the far origin; top written with upper bits set
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_WIDTH,  7'd0));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_HEIGHT, 7'd0));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_LEFT,   7'd127));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_TOP,    7'h7F));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h3C, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'h00, 8'hC8, 8'hC8));
    plan.push_back(item_row(dwce_pkg::KIND_GOTO, 8'h00, 8'h05, 8'h05, 2'd2,
                            lcd(1'b0, 8'hFF, 1'b0), lcd(1'b0, 8'h47, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_PASS, 8'h5A, 8'h00, 8'h00, 2'd1,
                            lcd(1'b0, 8'h5A, 1'b1)));
    // Oversized window clamps to the panel
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_WIDTH,  7'd127));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_HEIGHT, 7'h7F));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_LEFT,   7'd0));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_TOP,    7'd0));
    plan.push_back(item_row(dwce_pkg::KIND_GOTO, 8'h00, 8'd83, 8'd5, 2'd2,
                            lcd(1'b0, 8'hD3, 1'b0), lcd(1'b0, 8'h45, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h01, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_GOTO, 8'h00, 8'd83, 8'd5, 2'd2,
                            lcd(1'b0, 8'hD3, 1'b0), lcd(1'b0, 8'h45, 1'b1)));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'h00, 8'd83, 8'd47));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'h00, 8'd0,  8'd8));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h80, 8'h00, 8'h00));
    // Small offset window: a run of writes that wraps, then a dot
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_LEFT,   7'd80));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_TOP,    7'd5));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_WIDTH,  7'd4));
    plan.push_back(cfg_row(dwce_pkg::CFG_WIN_HEIGHT, 7'd2));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h11, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h22, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h33, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DATA, 8'h44, 8'h00, 8'h00));
    plan.push_back(item_row(dwce_pkg::KIND_DOT,  8'h00, 8'hFF, 8'hFF));

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed plan
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain_lcd_bytes();
        write_window_reg(plan[i].cfg_idx, plan[i].cfg_val);
        if (i + 1 == plan.size() || !plan[i+1].is_cfg) cfg_valid = 1'b0;
      end else begin
        idle_sender(sender_gap());
        send_item(plan[i].item, plan[i].n_typed, plan[i].typed);
      end
    end

    // Random phases, each under a freshly written window
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_lcd_bytes();
      nwrites = $urandom_range(1, 4);
      for (int j = 0; j < nwrites; j++) begin
        idx = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
          cfg_valid = 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        write_window_reg(idx, pick_window_value(idx));
      end
      cfg_valid = 1'b0;
      quiet  = ($urandom_range(0, 2) == 0);
      nitems = $urandom_range(15, 40);
      for (int j = 0; j < nitems && sent < RANDOM_ITEMS; j++) begin
        if ($urandom_range(0, 29) == 0) drain_lcd_bytes();
        else if (!quiet) idle_sender(sender_gap());
        send_item(random_item(), 2'd0, '0);
        sent++;
      end
    end

    drain_lcd_bytes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_lcd_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
